[sv/stereo_envelope_follower_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo envelope follower
// Immediate-consequence and next-cycle forms, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_ENVELOPE_FOLLOWER_ASSERT_SVH
`define STEREO_ENVELOPE_FOLLOWER_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define SEF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define SEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sef_pkg.sv]
// ----------------------------------------------------------------------------
// sef_pkg
// Types and fixed-point constants shared by the envelope follower modules.
// ----------------------------------------------------------------------------
package sef_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_W     = 16;
    localparam int ENV_W       = 20;
    localparam int CFG_IDX_W   = 3;

    // prev_out + x - prev_in needs two extra bits
    localparam int DIFF_W  = SAMPLE_BITS + 2;
    // |hp| fits SAMPLE_BITS unsigned, sum of two one more
    localparam int MAG_W   = SAMPLE_BITS;
    localparam int SUM_W   = SAMPLE_BITS + 1;

    localparam int MAC_A_W = (DIFF_W > ENV_W + 1) ? DIFF_W : ENV_W + 1;
    localparam int MAC_B_W = COEFF_W + 2;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = MAC_P_W + 1;

    localparam int DET_SHIFT = SAMPLE_BITS - 4;

    localparam logic signed [ACC_W-1:0] Q16_RND = ACC_W'(1) << (COEFF_W - 1);
    localparam logic signed [ACC_W-1:0] DET_RND = ACC_W'(1) << (DET_SHIFT - 1);

    localparam logic [MAC_B_W-1:0] COEFF_ONE = MAC_B_W'(1) << COEFF_W;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [ENV_W-1:0]              ENV_MAX = {ENV_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SENS     = CFG_IDX_W'(3);

    localparam logic [COEFF_W-1:0] HIGHPASS_RST = COEFF_W'(65365);
    localparam logic [COEFF_W-1:0] ATTACK_RST   = COEFF_W'(65399);
    localparam logic [COEFF_W-1:0] RELEASE_RST  = COEFF_W'(65522);
    localparam logic [COEFF_W-1:0] SENS_RST     = COEFF_W'(4096);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          mono;
        logic                          block_end;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic [ENV_W-1:0]              envelope;
        logic                          block_done;
    } result_t;

    // control for the shared multiply-accumulate
    typedef struct packed {
        logic en;      // load the accumulator this cycle
        logic chain;   // add to the accumulator rather than a rounding offset
        logic det_rnd; // detector rounding offset instead of Q16 half
    } mac_ctrl_t;

endpackage

[sv/sef_mac.sv]
// ----------------------------------------------------------------------------
// sef_mac
// Shared signed multiply-accumulate; one product per cycle into a register while ctrl.en is set.
// ----------------------------------------------------------------------------
module sef_mac (
    input  logic                              clk,
    input  sef_pkg::mac_ctrl_t                ctrl,
    input  logic signed [sef_pkg::MAC_A_W-1:0] op_a,
    input  logic signed [sef_pkg::MAC_B_W-1:0] op_b,
    output logic signed [sef_pkg::ACC_W-1:0]   acc
);
    import sef_pkg::*;

    logic signed [MAC_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    always_comb
    begin
        prod = op_a * op_b;
        if (ctrl.chain)
        begin
            base = acc_reg;
        end
        else if (ctrl.det_rnd)
        begin
            base = DET_RND;
        end
        else
        begin
            base = Q16_RND;
        end
        acc_next = base + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[sv/stereo_envelope_follower.sv]
// An accepted item steps S_HP_L to S_ENV_SAT, waits there while the last
// result stalls, then registers its result; no new item is taken before
// S_IDLE. The single shared multiply-accumulate takes five products per item
// (two filter taps, detector gain, two envelope terms) in eight steps.
// Reset: rst_n clears filter history, envelope and handshake state and loads
// the coefficient registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// stereo_envelope_follower
// Stereo high-pass, rectify and attack/release smoothing to a Q4.16 envelope.
// ----------------------------------------------------------------------------
`include "stereo_envelope_follower_assert.svh"

module stereo_envelope_follower (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample item channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  sef_pkg::sample_t                   sample,
    // result item channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output sef_pkg::result_t                   result,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sef_pkg::COEFF_W-1:0]        cfg_data
);
    import sef_pkg::*;

    // Sequencer: each working step loads the MAC, consumes its result, or both.
    typedef enum logic [3:0] {
        S_IDLE,
        S_HP_L,     // MAC: left filter product
        S_SAT_L,    // left saturate / store; MAC: right filter product
        S_SAT_R,    // right saturate / store, sum of magnitudes
        S_DET,      // MAC: sum * sensitivity
        S_DSAT,     // detector saturate, pick attack or release
        S_ENV1,     // MAC: c * envelope
        S_ENV2,     // MAC: += (1 - c) * detector
        S_ENV_SAT   // saturate envelope, publish result
    } state_t;

    state_t state_reg, state_next;

    logic [COEFF_W-1:0] hp_coeff_reg, hp_coeff_next;
    logic [COEFF_W-1:0] attack_reg, attack_next;
    logic [COEFF_W-1:0] release_reg, release_next;
    logic [COEFF_W-1:0] sens_reg, sens_next;

    logic signed [SAMPLE_BITS-1:0] prev_out_reg [2];
    logic signed [SAMPLE_BITS-1:0] prev_out_next [2];
    logic signed [SAMPLE_BITS-1:0] prev_in_reg [2];
    logic signed [SAMPLE_BITS-1:0] prev_in_next [2];
    logic [ENV_W-1:0]              env_reg, env_next;

    // working item and intermediates
    sample_t                    item_reg, item_next;
    logic signed [DIFF_W-1:0]   diff_reg [2];
    logic signed [DIFF_W-1:0]   diff_next [2];
    logic [MAG_W-1:0]           mag_l_reg, mag_l_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [ENV_W-1:0]           det_reg, det_next;
    logic [COEFF_W-1:0]         c_reg, c_next;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // shared MAC
    mac_ctrl_t                 mac_ctrl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_acc;

    // result taps on the accumulator
    logic signed [ACC_W-1:0]       hp_shift;
    logic                          hp_ovf;
    logic signed [SAMPLE_BITS-1:0] hp_sat;
    logic [MAG_W-1:0]              hp_mag;
    logic signed [ACC_W-1:0]       det_shift;
    logic [ENV_W-1:0]              det_sat;
    logic signed [ACC_W-1:0]       env_shift;
    logic [ENV_W-1:0]              env_sat;

    logic                          accept;
    logic                          publish;
    logic signed [SAMPLE_BITS-1:0] xr_in;

    sef_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign publish      = (state_reg == S_ENV_SAT) && (!result_valid_reg || !result_stall);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign xr_in        = sample.mono ? sample.left_sample : sample.right_sample;

    // Filter output: round(Q16), saturate to sample range, then magnitude.
    // Arithmetic shift gives floor, the rounding half is already in the MAC.
    always_comb
    begin
        hp_shift = mac_acc >>> COEFF_W;
        hp_ovf   = !((&hp_shift[ACC_W-1:SAMPLE_BITS-1]) || !(|hp_shift[ACC_W-1:SAMPLE_BITS-1]));
        if (hp_ovf)
        begin
            hp_sat = hp_shift[ACC_W-1] ? SMP_MIN : SMP_MAX;
        end
        else
        begin
            hp_sat = hp_shift[SAMPLE_BITS-1:0];
        end
        // most negative value maps to 2^(N-1), which still fits unsigned
        hp_mag = hp_sat[SAMPLE_BITS-1] ? MAG_W'(-hp_sat) : MAG_W'(hp_sat);

        // detector and envelope terms are never negative
        det_shift = mac_acc >>> DET_SHIFT;
        det_sat   = (|det_shift[ACC_W-1:ENV_W]) ? ENV_MAX : det_shift[ENV_W-1:0];
        env_shift = mac_acc >>> COEFF_W;
        env_sat   = (|env_shift[ACC_W-1:ENV_W]) ? ENV_MAX : env_shift[ENV_W-1:0];
    end

    // MAC operand selection per step
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        case (state_reg)
            S_HP_L:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = MAC_A_W'(diff_reg[0]);
                mac_b       = signed'({{(MAC_B_W-COEFF_W){1'b0}}, hp_coeff_reg});
            end
            S_SAT_L:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = MAC_A_W'(diff_reg[1]);
                mac_b       = signed'({{(MAC_B_W-COEFF_W){1'b0}}, hp_coeff_reg});
            end
            S_DET:
            begin
                mac_ctrl.en      = 1'b1;
                mac_ctrl.det_rnd = 1'b1;
                mac_a            = signed'({{(MAC_A_W-SUM_W){1'b0}}, sum_reg});
                mac_b            = signed'({{(MAC_B_W-COEFF_W){1'b0}}, sens_reg});
            end
            S_ENV1:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = signed'({{(MAC_A_W-ENV_W){1'b0}}, env_reg});
                mac_b       = signed'({{(MAC_B_W-COEFF_W){1'b0}}, c_reg});
            end
            S_ENV2:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.chain = 1'b1;
                mac_a          = signed'({{(MAC_A_W-ENV_W){1'b0}}, det_reg});
                mac_b          = signed'(COEFF_ONE - {{(MAC_B_W-COEFF_W){1'b0}}, c_reg});
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        hp_coeff_next     = hp_coeff_reg;
        attack_next       = attack_reg;
        release_next      = release_reg;
        sens_next         = sens_reg;
        prev_out_next     = prev_out_reg;
        prev_in_next      = prev_in_reg;
        env_next          = env_reg;
        item_next         = item_reg;
        diff_next         = diff_reg;
        mag_l_next        = mag_l_reg;
        sum_next          = sum_reg;
        det_next          = det_reg;
        c_next            = c_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        // Send config only while idle, unchecked; out-of-range indexes are dropped.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HIGHPASS: hp_coeff_next = cfg_data;
                CFG_ATTACK:   attack_next   = cfg_data;
                CFG_RELEASE:  release_next  = cfg_data;
                CFG_SENS:     sens_next     = cfg_data;
                default:      hp_coeff_next = hp_coeff_reg;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next              = sample;
                    item_next.right_sample = xr_in;
                    diff_next[0] = DIFF_W'(prev_out_reg[0]) + DIFF_W'(sample.left_sample)
                                 - DIFF_W'(prev_in_reg[0]);
                    diff_next[1] = DIFF_W'(prev_out_reg[1]) + DIFF_W'(xr_in)
                                 - DIFF_W'(prev_in_reg[1]);
                    state_next   = S_HP_L;
                end
            end
            S_HP_L:
            begin
                state_next = S_SAT_L;
            end
            S_SAT_L:
            begin
                prev_out_next[0] = hp_sat;
                prev_in_next[0]  = item_reg.left_sample;
                mag_l_next       = hp_mag;
                state_next       = S_SAT_R;
            end
            S_SAT_R:
            begin
                prev_out_next[1] = hp_sat;
                prev_in_next[1]  = item_reg.right_sample;
                sum_next         = SUM_W'(mag_l_reg) + SUM_W'(hp_mag);
                state_next       = S_DET;
            end
            S_DET:
            begin
                state_next = S_DSAT;
            end
            S_DSAT:
            begin
                det_next   = det_sat;
                c_next     = (det_sat > env_reg) ? attack_reg : release_reg;
                state_next = S_ENV1;
            end
            S_ENV1:
            begin
                state_next = S_ENV2;
            end
            S_ENV2:
            begin
                state_next = S_ENV_SAT;
            end
            S_ENV_SAT:
            begin
                // hold here while the previous result is still waiting
                if (publish)
                begin
                    env_next               = env_sat;
                    result_next.left_out   = item_reg.left_sample;
                    result_next.right_out  = item_reg.right_sample;
                    result_next.envelope   = env_sat;
                    result_next.block_done = item_reg.block_end;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            hp_coeff_reg     <= HIGHPASS_RST;
            attack_reg       <= ATTACK_RST;
            release_reg      <= RELEASE_RST;
            sens_reg         <= SENS_RST;
            prev_out_reg[0]  <= '0;
            prev_out_reg[1]  <= '0;
            prev_in_reg[0]   <= '0;
            prev_in_reg[1]   <= '0;
            env_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            hp_coeff_reg     <= hp_coeff_next;
            attack_reg       <= attack_next;
            release_reg      <= release_next;
            sens_reg         <= sens_next;
            prev_out_reg     <= prev_out_next;
            prev_in_reg      <= prev_in_next;
            env_reg          <= env_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        diff_reg   <= diff_next;
        mag_l_reg  <= mag_l_next;
        sum_reg    <= sum_next;
        det_reg    <= det_next;
        c_reg      <= c_next;
        result_reg <= result_next;
    end

    `SEF_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_HP_L, "accept did not start filter")
    `SEF_ASSERT_SAME(a_coeff_pick, state_reg == S_ENV1, c_reg == attack_reg || c_reg == release_reg, "bad coeff")
    `SEF_ASSERT_SAME(a_result_source, $rose(result_valid_reg), $past(state_reg == S_ENV_SAT), "stray result")
    `SEF_ASSERT_NEXT(a_env_published, publish, result_reg.envelope == env_reg && state_reg == S_IDLE, "env")

endmodule

[verif/tb_stereo_envelope_follower.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_envelope_follower
// Self-checking bench: a queue-fed driver pushes sample items, an internal
// predictor works out the envelope for each accepted item, and a monitor
// compares every result item against the oldest prediction. Coefficients are
// changed between phases only once the block has drained.
// ----------------------------------------------------------------------------
module tb_stereo_envelope_follower;

    import sef_pkg::*;

    // first register index past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_SENS + CFG_IDX_W'(1);
    localparam longint ENV_LIMIT = longint'(ENV_MAX);
    localparam int     DRAIN_CYCLES = 16;     // comfortably longer than one item's trip through the sequencer

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample       = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [COEFF_W-1:0]   cfg_data     = '0;

    stereo_envelope_follower u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    sample_t pending_q[$];      // items waiting for the driver
    result_t expect_q[$];       // predicted results, oldest first

    int send_idle_pct  = 11;    // chance the driver leaves a cycle empty
    int recv_stall_pct = 49;    // chance the monitor stalls the result side

    int items_sent     = 0;
    int mono_items     = 0;
    int block_ends     = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int settings_used  = 1;     // reset defaults count as the first

    // predictor copy of the coefficient registers
    logic [COEFF_W-1:0] highpass_q = HIGHPASS_RST;
    logic [COEFF_W-1:0] attack_q   = ATTACK_RST;
    logic [COEFF_W-1:0] release_q  = RELEASE_RST;
    logic [COEFF_W-1:0] sens_q     = SENS_RST;

    // predictor copy of the filter history and envelope
    logic signed [SAMPLE_BITS-1:0] hp_prev_in  [2] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] hp_prev_out [2] = '{default: '0};
    logic [ENV_W-1:0]              env_level       = '0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // one-pole high-pass for one channel; returns the rectified output and
    // keeps the saturated value as history
    function automatic longint highpass_mag(input int ch, input longint x);
        longint diff;
        longint y;
        diff = longint'(hp_prev_out[ch]) + x - longint'(hp_prev_in[ch]);
        // round half up, arithmetic shift floors negatives correctly
        y = (longint'(highpass_q) * diff + 64'sd32768) >>> 16;
        if (y > longint'(SMP_MAX))
            y = longint'(SMP_MAX);
        if (y < longint'(SMP_MIN))
            y = longint'(SMP_MIN);
        hp_prev_in[ch]  = x[SAMPLE_BITS-1:0];
        hp_prev_out[ch] = y[SAMPLE_BITS-1:0];
        return (y < 0) ? -y : y;
    endfunction

    function automatic result_t envelope_step(input sample_t s);
        result_t r;
        longint  xl;
        longint  xr;
        longint  level_sum;
        longint  det;
        longint  c;
        longint  acc;
        xl = longint'(s.left_sample);
        xr = s.mono ? xl : longint'(s.right_sample);
        level_sum = highpass_mag(0, xl);
        level_sum = level_sum + highpass_mag(1, xr);

        // detector: Q1.16 magnitude sum times Q4.12 gain, into Q4.16
        det = (level_sum * longint'(sens_q) + (64'sd1 << (SAMPLE_BITS - 5)))
              >> (SAMPLE_BITS - 4);
        if (det > ENV_LIMIT)
            det = ENV_LIMIT;

        // attack only on a strictly rising level
        c = (det > longint'(env_level)) ? longint'(attack_q) : longint'(release_q);
        acc = (c * longint'(env_level) + (64'sd65536 - c) * det + 64'sd32768) >> 16;
        if (acc > ENV_LIMIT)
            acc = ENV_LIMIT;
        env_level = acc[ENV_W-1:0];

        r.left_out   = s.left_sample;
        r.right_out  = xr[SAMPLE_BITS-1:0];
        r.envelope   = env_level;
        r.block_done = s.block_end;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expect_q.push_back(envelope_step(sample));
                items_sent++;
                if (sample.mono)
                    mono_items++;
                if (sample.block_end)
                    block_ends++;
            end
            // a stalled item stays put; otherwise load the next or go idle
            if (!sample_valid || !sample_stall)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_q.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compares each accepted result item
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result item: L=%0d R=%0d env=%0d done=%0b",
                                 $time, result.left_out, result.right_out,
                                 result.envelope, result.block_done);
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (result.left_out   !== want.left_out  ||
                        result.right_out  !== want.right_out ||
                        result.envelope   !== want.envelope  ||
                        result.block_done !== want.block_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] result %0d: got  L=%0d R=%0d env=%0d done=%0b",
                                     $time, results_seen,
                                     result.left_out, result.right_out,
                                     result.envelope, result.block_done);
                            $display("[%0t] result %0d: want L=%0d R=%0d env=%0d done=%0b",
                                     $time, results_seen,
                                     want.left_out, want.right_out,
                                     want.envelope, want.block_done);
                        end
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // register write over the config channel; only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HIGHPASS: highpass_q = val;
            CFG_ATTACK:   attack_q   = val;
            CFG_RELEASE:  release_q  = val;
            CFG_SENS:     sens_q     = val;
            default:      ;                 // unmapped index, dropped
        endcase
    endtask

    task automatic push_item(input int l, input int r, input bit mono, input bit be);
        sample_t s;
        s.left_sample  = l[SAMPLE_BITS-1:0];
        s.right_sample = r[SAMPLE_BITS-1:0];
        s.mono         = mono;
        s.block_end    = be;
        pending_q.push_back(s);
    endtask

    // sample value shaped by burst style: silence, extremes, quiet, medium, full
    function automatic logic [SAMPLE_BITS-1:0] random_sample(input int style);
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        case (style)
            0:       v = '0;
            1:
            begin
                case ($urandom_range(2))
                    0:       v = SMP_MAX;
                    1:       v = SMP_MIN;
                    default: v = '0;
                endcase
            end
            2, 3:    v = v >>> 10;
            4, 5:    v = v >>> 4;
            default: ;
        endcase
        return v;
    endfunction

    // bursts of a common style, so the envelope both climbs and decays
    task automatic queue_random(input int count);
        sample_t s;
        int      burst_left;
        int      style;
        burst_left = 0;
        style      = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 4);
                style      = $urandom_range(9);
            end
            burst_left--;
            s.left_sample  = random_sample(style);
            s.right_sample = random_sample(style);
            s.mono         = ($urandom_range(3) == 0);
            s.block_end    = (burst_left == 0) || ($urandom_range(15) == 0);
            pending_q.push_back(s);
        end
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || sample_valid || expect_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- reset coefficients; sender idles lightly, receiver heavily ---
        send_idle_pct  = 11;
        recv_stall_pct = 49;

        // directed: silence, full-scale swings that drive the filters into
        // saturation, mono with a conflicting right sample, then decay
        push_item(0, 0, 1'b0, 1'b0);
        push_item(32767, -32768, 1'b0, 1'b1);
        push_item(-32768, 32767, 1'b0, 1'b0);
        push_item(32767, -32768, 1'b0, 1'b0);
        push_item(-32768, 32767, 1'b0, 1'b0);
        push_item(32767, 32767, 1'b0, 1'b0);
        push_item(-32768, -32768, 1'b0, 1'b1);
        push_item(32767, -32768, 1'b1, 1'b0);   // right ignored in mono
        push_item(-32768, 12345, 1'b1, 1'b1);
        push_item(32767, 0, 1'b1, 1'b0);
        push_item(-1, 1, 1'b0, 1'b0);
        push_item(1, -1, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
            push_item(0, 0, 1'b0, (i == 5));    // release towards zero
        push_item(21845, -21846, 1'b0, 1'b0);
        push_item(-21846, 21845, 1'b1, 1'b1);
        wait_drained();

        queue_random(130);
        wait_drained();

        // --- extremes: widest pole, instant attack and release, top gain ---
        write_reg(CFG_HIGHPASS, 16'hFFFF);
        write_reg(CFG_ATTACK,   16'h0000);
        write_reg(CFG_RELEASE,  16'h0000);
        write_reg(CFG_SENS,     16'hFFFF);
        // unmapped index must leave every register untouched
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(3)), COEFF_W'($urandom));
        settings_used++;
        push_item(32767, -32768, 1'b0, 1'b0);
        push_item(-32768, 32767, 1'b0, 1'b1);
        push_item(0, 0, 1'b0, 1'b1);
        queue_random(100);
        wait_drained();

        // --- other extremes; now the receiver is the light one ---
        send_idle_pct  = 49;
        recv_stall_pct = 11;
        write_reg(CFG_HIGHPASS, 16'h0000);
        write_reg(CFG_ATTACK,   16'hFFFF);
        write_reg(CFG_RELEASE,  16'hFFFF);
        write_reg(CFG_SENS,     16'h0000);
        settings_used++;
        queue_random(30);
        wait_drained();

        // --- a few random coefficient sets, pole kept near audio values ---
        for (int k = 0; k < 3; k++)
        begin
            write_reg(CFG_HIGHPASS, COEFF_W'($urandom_range(65535, 60000)));
            write_reg(CFG_ATTACK,   COEFF_W'($urandom));
            write_reg(CFG_RELEASE,  COEFF_W'($urandom));
            write_reg(CFG_SENS,     COEFF_W'($urandom));
            settings_used++;
            queue_random(60);
            wait_drained();
        end

        // --- back to the reset values, no idling on either side ---
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_HIGHPASS, HIGHPASS_RST);
        write_reg(CFG_ATTACK,   ATTACK_RST);
        write_reg(CFG_RELEASE,  RELEASE_RST);
        write_reg(CFG_SENS,     SENS_RST);
        settings_used++;
        queue_random(160);
        wait_drained();

        // let any stray result item surface before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sample items (%0d mono, %0d block ends) over %0d coeff sets.",
                 items_sent, mono_items, block_ends, settings_used);
        $display("%0d result items checked, %0d mismatching.", results_seen, mismatches);
        if (mismatches == 0)
            $display("** stereo_envelope_follower: PASSED **");
        else
            $display("** stereo_envelope_follower: FAILED **");
        $finish;
    end

    // hang guard: the slowest expected run is well under a tenth of this
    initial
    begin : watchdog
        #4_000_000;
        $display("Run stopped by the watchdog with %0d results outstanding.", expect_q.size());
        $display("** stereo_envelope_follower: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sef_pkg.sv
sv/sef_mac.sv
sv/stereo_envelope_follower.sv
verif/tb_stereo_envelope_follower.sv
